FILE: design/wbps_pkg.sv
// Shared types and constants for the windowed best-pair selector.
package wbps_pkg;

  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 31;

  localparam logic [CFG_IW-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PAIR_STEP = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RANGE_START = 2'd2;
  localparam logic [CFG_IW-1:0] REG_RANGE_END = 2'd3;

  localparam logic [31:0] CUT_OFS_REV = 32'd2;
  localparam logic [31:0] CUT_OFS_FWD = 32'd17;

  typedef struct packed {
    logic [30:0] align_start;
    logic        strand_reverse;
    logic [39:0] guide_code;
    logic [15:0] score;
  } in_t;

  typedef struct packed {
    logic [39:0] first_guide;
    logic [30:0] first_cut;
    logic        first_reversed;
    logic [15:0] first_score;
    logic [39:0] second_guide;
    logic [30:0] second_cut;
    logic        second_reversed;
    logic [15:0] second_score;
    logic [30:0] distance;
  } out_t;

  typedef struct packed {
    logic [30:0] cut;
    logic        reversed;
    logic [39:0] guide;
    logic [15:0] score;
  } rec_t;

  typedef struct packed {
    logic [20:0] half;
    logic [5:0]  stride;
  } back_cfg_t;

endpackage

FILE: design/wbps_front.sv
// Front stage: cut position and range filter.
module wbps_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wbps_pkg::in_t      in_item,
  input  logic [30:0]        range_start,
  input  logic [30:0]        range_end,
  output logic               push,
  output wbps_pkg::rec_t     push_rec,
  input  logic               full
);

  logic           stg_valid;
  logic           stg_keep;
  wbps_pkg::rec_t stg_rec;
  logic [31:0]    cut;
  logic           keep;
  logic           advance;

  assign cut = {1'b0, in_item.align_start} +
               (in_item.strand_reverse ? wbps_pkg::CUT_OFS_REV : wbps_pkg::CUT_OFS_FWD);
  assign keep = (cut >= {1'b0, range_start}) && (cut <= {1'b0, range_end});

  assign push = stg_valid && stg_keep && !full;
  assign push_rec = stg_rec;
  assign advance = !stg_valid || !stg_keep || !full;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (advance) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      stg_keep <= keep;
      stg_rec.cut <= cut[30:0];
      stg_rec.reversed <= in_item.strand_reverse;
      stg_rec.guide <= in_item.guide_code;
      stg_rec.score <= in_item.score;
    end
  end

endmodule

FILE: design/wbps_fifo.sv
// Short record queue between front and back.
module wbps_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wbps_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output wbps_pkg::rec_t pop_rec
);

  wbps_pkg::rec_t                 mem [wbps_pkg::FIFO_DEPTH];
  logic [wbps_pkg::FIFO_AW-1:0]   wptr;
  logic [wbps_pkg::FIFO_AW-1:0]   rptr;
  logic [wbps_pkg::FIFO_AW:0]     count;

  assign full = (count == (wbps_pkg::FIFO_AW + 1)'(wbps_pkg::FIFO_DEPTH));
  assign avail = (count != '0);
  assign pop_rec = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_rec;
    end
  end

endmodule

FILE: design/wbps_div.sv
// Radix-2 restoring divider for the window index, one quotient bit per cycle.
module wbps_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [20:0] den,
  output logic        done,
  output logic [30:0] quo
);

  logic        busy;
  logic [4:0]  cnt;
  logic [20:0] rem;
  logic [21:0] sh;
  logic        ge;

  assign sh = {rem, quo[30]};
  assign ge = (sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (ge) begin
        rem <= 21'(sh - {1'b0, den});
      end else begin
        rem <= sh[20:0];
      end
      quo <= {quo[29:0], ge};
    end
  end

endmodule

FILE: design/wbps_back.sv
// Back part: window index, per-window best, selection history and pairing.
module wbps_back (
  input  logic                clk,
  input  logic                rst,
  input  wbps_pkg::back_cfg_t cfg,
  input  logic                avail,
  input  wbps_pkg::rec_t      pop_rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output wbps_pkg::out_t      out_item
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_UPD = 2'd2;
  localparam logic [1:0] ST_PAIR = 2'd3;

  logic [1:0]     state;
  wbps_pkg::rec_t cur;
  wbps_pkg::rec_t best;
  wbps_pkg::rec_t sec;
  wbps_pkg::rec_t rd_data;
  logic [30:0]    last_window;
  logic           has_entry;
  logic [31:0]    sel_count;
  logic           div_done;
  logic [30:0]    win;
  logic           new_win;
  logic           flush;
  logic           same_has;
  logic [31:0]    diff;
  logic           pair_ok;
  logic           out_free;
  logic           upd_go;
  logic [wbps_pkg::HIST_AW-1:0] wslot;
  logic [wbps_pkg::HIST_AW-1:0] rslot;
  wbps_pkg::rec_t hist [wbps_pkg::HIST_DEPTH];

  wbps_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(pop),
    .num  (pop_rec.cut),
    .den  (cfg.half),
    .done (div_done),
    .quo  (win)
  );

  assign pop = (state == ST_IDLE) && avail;
  assign new_win = (win != last_window);
  assign flush = new_win && has_entry;
  assign same_has = !new_win && has_entry;
  assign diff = sel_count - 32'(cfg.stride);
  assign pair_ok = ({1'b0, cfg.stride} < 7'(wbps_pkg::HIST_DEPTH)) &&
                   (sel_count >= 32'(cfg.stride)) && !diff[0];
  assign wslot = sel_count[wbps_pkg::HIST_AW-1:0];
  assign rslot = diff[wbps_pkg::HIST_AW-1:0];
  assign out_free = !out_valid || out_ready;
  assign upd_go = (state == ST_UPD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last_window <= '0;
      has_entry <= 1'b0;
      sel_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (avail) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            has_entry <= 1'b1;
            last_window <= win;
            state <= ST_IDLE;
            if (flush) begin
              sel_count <= sel_count + 1'b1;
              if (pair_ok) begin
                state <= ST_PAIR;
              end
            end
          end
        end
        ST_PAIR: begin
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_rec;
    end
    if (upd_go) begin
      if (flush) begin
        sec <= best;
      end
      if (!same_has || (cur.score > best.score)) begin
        best <= cur;
      end
    end
    if (state == ST_PAIR) begin
      out_item.first_guide <= rd_data.guide;
      out_item.first_cut <= rd_data.cut;
      out_item.first_reversed <= rd_data.reversed;
      out_item.first_score <= rd_data.score;
      out_item.second_guide <= sec.guide;
      out_item.second_cut <= sec.cut;
      out_item.second_reversed <= sec.reversed;
      out_item.second_score <= sec.score;
      out_item.distance <= sec.cut - rd_data.cut;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go && flush) begin
      hist[wslot] <= best;
    end
    rd_data <= hist[rslot];
  end

endmodule

FILE: design/windowed_best_pair_selector_core.sv
// Top level of the windowed best-pair selector: configuration registers and wiring.
//
//  channel | signals                        | transfer when
//  in      | in_valid, in_ready, in_item    | in_valid && in_ready
//  out     | out_valid, out_ready, out_item | out_valid && out_ready
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
// In the back part each kept record goes through a pop, the one-bit-per-cycle window
// divider (31 bits plus done), an update, and a pair read when a pair is emitted.
// The front takes one record per cycle into a 4-entry queue until it fills.
// Dropped records pass through the front only.
// Synchronous reset clears control state; history contents are not cleared.
// A stalled output holds the back part before the next window update.
module windowed_best_pair_selector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wbps_pkg::in_t                 in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wbps_pkg::out_t                out_item,
  input  logic                          cfg_we,
  input  logic [wbps_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DW-1:0]   cfg_data
);

  logic [20:0]         window_size;
  logic [4:0]          pair_step;
  logic [30:0]         range_start;
  logic [30:0]         range_end;
  logic [21:0]         ws_inc;
  logic [4:0]          ps_eff;
  wbps_pkg::back_cfg_t bcfg;
  logic                push;
  wbps_pkg::rec_t      push_rec;
  logic                full;
  logic                pop;
  logic                avail;
  wbps_pkg::rec_t      pop_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 21'd40;
      pair_step <= 5'd1;
      range_start <= '0;
      range_end <= 31'h7FFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbps_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[20:0];
        wbps_pkg::REG_PAIR_STEP:   pair_step <= cfg_data[4:0];
        wbps_pkg::REG_RANGE_START: range_start <= cfg_data;
        wbps_pkg::REG_RANGE_END:   range_end <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ws_inc = {1'b0, window_size} + 22'd1;
  assign bcfg.half = (ws_inc[21:1] == '0) ? 21'd1 : ws_inc[21:1];
  assign ps_eff = (pair_step == '0) ? 5'd1 : pair_step;
  assign bcfg.stride = {ps_eff, 1'b0} - 6'd1;

  wbps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .range_start(range_start),
    .range_end  (range_end),
    .push       (push),
    .push_rec   (push_rec),
    .full       (full)
  );

  wbps_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .full    (full),
    .pop     (pop),
    .avail   (avail),
    .pop_rec (pop_rec)
  );

  wbps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (bcfg),
    .avail    (avail),
    .pop_rec  (pop_rec),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

FILE: design/wbps_checker.sv
// Port-level checks for the windowed best-pair selector.
module wbps_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input wbps_pkg::out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("out_item changed while stalled");

  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_distance: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.distance == 31'(out_item.second_cut - out_item.first_cut))
    else $error("distance mismatch");

endmodule

bind windowed_best_pair_selector_core wbps_checker u_wbps_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

FILE: tb/windowed_best_pair_selector_core_tb.sv
// Self-checking testbench for windowed_best_pair_selector_core.
`timescale 1ns / 1ps

module windowed_best_pair_selector_core_tb;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  wbps_pkg::in_t in_item;
  logic out_valid;
  logic out_ready;
  wbps_pkg::out_t out_item;
  logic cfg_we;
  logic [wbps_pkg::CFG_IW-1:0] cfg_index;
  logic [wbps_pkg::CFG_DW-1:0] cfg_data;

  windowed_best_pair_selector_core i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [20:0] m_window;
  logic [4:0] m_pair_step;
  logic [30:0] m_range_start;
  logic [30:0] m_range_end;
  logic [31:0] m_last_win;
  logic m_has_entry;
  wbps_pkg::rec_t m_best;
  logic [31:0] m_sel_count;
  wbps_pkg::rec_t m_hist [wbps_pkg::HIST_DEPTH];

  wbps_pkg::out_t pending_pairs[$];
  int mismatches;
  int cycle_count;
  int rx_hold;
  bit rx_steady;
  bit tx_steady;
  logic [30:0] walk_pos;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %h got %h", field, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result checker and receiver idling
  always @(posedge clk) begin
    wbps_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        if (mismatches < 10) $display("unexpected transfer %h", out_item);
        mismatches++;
      end else begin
        e = pending_pairs.pop_front();
        note_mismatch("first_guide", 64'(e.first_guide), 64'(out_item.first_guide));
        note_mismatch("first_cut", 64'(e.first_cut), 64'(out_item.first_cut));
        note_mismatch("first_reversed", 64'(e.first_reversed),
                      64'(out_item.first_reversed));
        note_mismatch("first_score", 64'(e.first_score), 64'(out_item.first_score));
        note_mismatch("second_guide", 64'(e.second_guide), 64'(out_item.second_guide));
        note_mismatch("second_cut", 64'(e.second_cut), 64'(out_item.second_cut));
        note_mismatch("second_reversed", 64'(e.second_reversed),
                      64'(out_item.second_reversed));
        note_mismatch("second_score", 64'(e.second_score), 64'(out_item.second_score));
        note_mismatch("distance", 64'(e.distance), 64'(out_item.distance));
      end
    end
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_steady || ($urandom % 100 >= 24);
    end
  end

  task automatic predict_pair(input wbps_pkg::in_t r);
    logic [31:0] cut, half, win, ps, stride, k, p;
    wbps_pkg::out_t o;
    cut = {1'b0, r.align_start} +
          (r.strand_reverse ? wbps_pkg::CUT_OFS_REV : wbps_pkg::CUT_OFS_FWD);
    if (cut < {1'b0, m_range_start} || cut > {1'b0, m_range_end}) return;
    half = ({11'd0, m_window} + 32'd1) / 32'd2;
    if (half == 0) half = 1;
    win = cut / half;
    if (win != m_last_win) begin
      if (m_has_entry) begin
        k = m_sel_count;
        m_hist[k % wbps_pkg::HIST_DEPTH] = m_best;
        m_sel_count = k + 1;
        ps = (m_pair_step == 0) ? 32'd1 : {27'd0, m_pair_step};
        stride = 2 * ps - 1;
        if (!(stride >= wbps_pkg::HIST_DEPTH || k < stride || ((k - stride) & 1))) begin
          p = (k - stride) % wbps_pkg::HIST_DEPTH;
          o.first_guide = m_hist[p].guide;
          o.first_cut = m_hist[p].cut;
          o.first_reversed = m_hist[p].reversed;
          o.first_score = m_hist[p].score;
          o.second_guide = m_best.guide;
          o.second_cut = m_best.cut;
          o.second_reversed = m_best.reversed;
          o.second_score = m_best.score;
          o.distance = m_best.cut - m_hist[p].cut;
          pending_pairs.insert(pending_pairs.size(), o);
        end
      end
      m_has_entry = 1'b0;
    end
    if (!m_has_entry || r.score > m_best.score) begin
      m_best.cut = cut[30:0];
      m_best.reversed = r.strand_reverse;
      m_best.guide = r.guide_code;
      m_best.score = r.score;
    end
    m_has_entry = 1'b1;
    m_last_win = win;
  endtask

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_record(input wbps_pkg::in_t r);
    in_valid <= 1'b1;
    in_item <= r;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    predict_pair(r);
  endtask

  task automatic send_fields(input logic [30:0] start, input logic rev,
                             input logic [39:0] guide, input logic [15:0] score);
    wbps_pkg::in_t r;
    r.align_start = start;
    r.strand_reverse = rev;
    r.guide_code = guide;
    r.score = score;
    send_record(r);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [20:0] ws, input logic [4:0] ps,
                            input logic [30:0] rs, input logic [30:0] re);
    cfg_we <= 1'b1;
    cfg_index <= wbps_pkg::REG_WINDOW_SIZE;
    cfg_data <= {10'd0, ws};
    @(posedge clk);
    cfg_index <= wbps_pkg::REG_PAIR_STEP;
    cfg_data <= {26'd0, ps};
    @(posedge clk);
    cfg_index <= wbps_pkg::REG_RANGE_START;
    cfg_data <= rs;
    @(posedge clk);
    cfg_index <= wbps_pkg::REG_RANGE_END;
    cfg_data <= re;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_window = ws;
    m_pair_step = ps;
    m_range_start = rs;
    m_range_end = re;
  endtask

  // mostly ascending records with random content, some jumps and ties
  task automatic send_random(input int count, input int max_step);
    wbps_pkg::in_t r;
    int gap;
    for (int i = 0; i < count; i++) begin
      if (!tx_steady && ($urandom % 100 < 24)) begin
        gap = $urandom_range(1, 4);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom % 100 < 90) begin
        walk_pos = walk_pos + 31'($urandom_range(0, max_step));
        if (walk_pos > 31'h7F00_0000) walk_pos = 31'($urandom_range(0, 1000));
        r.align_start = walk_pos;
      end else begin
        r.align_start = 31'($urandom);
      end
      r.strand_reverse = 1'($urandom);
      r.guide_code = 40'({$urandom, $urandom});
      r.score = ($urandom % 4 == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      send_record(r);
    end
  endtask

  task automatic test_directed();
    // first record lands in window 0 and flushes nothing
    send_fields(31'd0, 1'b1, 40'h00_0000_0000, 16'h0000);
    send_fields(31'd3, 1'b0, 40'hFF_FFFF_FFFF, 16'hFFFF);
    // tie in window 1, but the earlier higher score stays best
    send_fields(31'd30, 1'b1, 40'hAA_AAAA_AAAA, 16'h1000);
    send_fields(31'd21, 1'b0, 40'h55_5555_5555, 16'h1000);
    send_fields(31'd50, 1'b0, 40'h12_3456_789A, 16'h0001);
    send_fields(31'd80, 1'b1, 40'h0F_0F0F_0F0F, 16'h8000);
    send_fields(31'd120, 1'b0, 40'hF0_F0F0_F0F0, 16'h7FFF);
    // cut past 31 bits is dropped
    send_fields(31'h7FFF_FFFF, 1'b0, 40'hFF_FFFF_FFFF, 16'hFFFF);
    send_fields(31'h7FFF_FFED, 1'b0, 40'h01_0203_0405, 16'h0002);
    // unsorted: cut falls back from near the top of the range
    send_fields(31'd200, 1'b1, 40'h33_3333_3333, 16'h0003);
    send_fields(31'd400, 1'b0, 40'h44_4444_4444, 16'h0004);
    send_fields(31'd600, 1'b1, 40'h66_6666_6666, 16'h0005);
    wait_drained();
    // range limits, zero window and zero pair-step registers
    set_config(21'd0, 5'd0, 31'd100, 31'd500);
    send_fields(31'd98, 1'b1, 40'h11_1111_1111, 16'h0100);
    send_fields(31'd97, 1'b1, 40'h22_2222_2222, 16'h0200);
    send_fields(31'd483, 1'b0, 40'h77_7777_7777, 16'h0300);
    send_fields(31'd484, 1'b0, 40'h88_8888_8888, 16'h0400);
    send_fields(31'd600, 1'b1, 40'h99_9999_9999, 16'h0500);
    for (int i = 0; i < 6; i++)
      send_fields(31'd150 + 31'(i * 20), i[0], 40'({$urandom, $urandom}),
                  16'($urandom));
    wait_drained();
  endtask

  task automatic test_config_sweep();
    set_config(21'd1, 5'd1, 31'd0, 31'h7FFF_FFFF);
    send_random(250, 3);
    wait_drained();
    set_config(21'd40, 5'd16, 31'd0, 31'h7FFF_FFFF);
    send_random(350, 40);
    wait_drained();
    set_config(21'd7, 5'd3, 31'd1000, 31'd2_000_000);
    walk_pos = 31'd900;
    send_random(300, 8);
    wait_drained();
    set_config(21'h10_0000, 5'd2, 31'd0, 31'h7FFF_FFFF);
    walk_pos = 31'd0;
    send_random(60, 1_100_000);
    wait_drained();
    set_config(21'd9, 5'd20, 31'd0, 31'h7FFF_FFFF);
    send_random(60, 10);
    wait_drained();
    set_config(21'h1F_FFFF, 5'd31, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_random(20, 1000);
    wait_drained();
  endtask

  task automatic test_pressure();
    set_config(21'd10, 5'd1, 31'd0, 31'h7FFF_FFFF);
    walk_pos = 31'd0;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_random(250, 12);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_hold = 2000;
    send_random(60, 12);
    wait_drained();
    send_random(150, 12);
    wait_drained();
    send_random(300, 15);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = wbps_pkg::REG_WINDOW_SIZE;
    cfg_data = '0;
    mismatches = 0;
    cycle_count = 0;
    rx_hold = 0;
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    walk_pos = 31'd0;
    m_window = 21'd40;
    m_pair_step = 5'd1;
    m_range_start = 31'd0;
    m_range_end = 31'h7FFF_FFFF;
    m_last_win = 32'd0;
    m_has_entry = 1'b0;
    m_best = '0;
    m_sel_count = 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_pressure();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/wbps_pkg.sv
design/wbps_front.sv
design/wbps_fifo.sv
design/wbps_div.sv
design/wbps_back.sv
design/windowed_best_pair_selector_core.sv
design/wbps_checker.sv
tb/windowed_best_pair_selector_core_tb.sv
